// ===== hdl/bpmc_pkg.sv =====
`timescale 1ns / 1ps
package bpmc_pkg;

    localparam int unsigned CW = 20;

    localparam logic [2:0] BASE_A = 3'd0;
    localparam logic [2:0] BASE_C = 3'd1;
    localparam logic [2:0] BASE_G = 3'd2;
    localparam logic [2:0] BASE_T = 3'd3;
    localparam logic [2:0] BASE_N = 3'd4;

    localparam logic [0:0] MODE_ADD    = 1'b0;
    localparam logic [0:0] MODE_REPORT = 1'b1;

    localparam logic [0:0] REG_WINDOW_START  = 1'b0;
    localparam logic [0:0] REG_WINDOW_LENGTH = 1'b1;

    typedef struct packed {
        logic [0:0]  mode;
        logic [31:0] location;
        logic [2:0]  read_base;
        logic [2:0]  ref_base;
    } in_item_t;

    typedef struct packed {
        logic          in_window;
        logic [CW-1:0] coverage;
        logic [CW-1:0] mismatch_total;
        logic [6:0]    mismatch_percent;
        logic [2:0]    dominant_base;
        logic          dominant_weak;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_DIV,
        ST_OUT
    } back_state_t;

endpackage

// ===== hdl/bpmc_front.sv =====
`timescale 1ns / 1ps
module bpmc_front #(
    parameter int unsigned WINDOW_DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [31:0]                   win_start,
    input  logic [10:0]                   win_len,
    input  logic                          in_valid,
    input  bpmc_pkg::in_item_t            in_item,
    output logic                          in_stall,
    output logic                          q_valid,
    output logic                          q_hit,
    output logic                          q_add,
    output logic                          q_mis,
    output logic [1:0]                    q_base,
    output logic [$clog2(WINDOW_DEPTH)-1:0] q_pos,
    input  logic                          q_pop,
    input  logic                          busy
);
    import bpmc_pkg::*;
    localparam int AW = $clog2(WINDOW_DEPTH);

    // two-entry queue
    logic [1:0]          cnt_reg, cnt_next;
    logic                rd_reg, wr_reg;
    logic [AW+4:0]       ent_reg [2];
    logic [32:0]         off;
    logic [32:0]         lim;
    logic                hit;
    logic [2:0]          rb, fb;
    logic [AW+4:0]       ent;
    logic                push;

    assign off = {1'b0, in_item.location} - {1'b0, win_start};
    always_comb
    begin
        if (32'(win_len) > 32'(WINDOW_DEPTH))
            lim = 33'(WINDOW_DEPTH);
        else
            lim = 33'(win_len);
    end
    assign hit = !off[32] && (off < lim);
    assign rb  = (in_item.read_base > BASE_N) ? BASE_N : in_item.read_base;
    assign fb  = (in_item.ref_base > BASE_N) ? BASE_N : in_item.ref_base;
    assign ent = {hit, (in_item.mode == MODE_ADD),
                  (rb != BASE_N) && (fb != BASE_N) && (rb != fb),
                  rb[1:0], off[AW-1:0]};

    assign in_stall = busy || (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign {q_hit, q_add, q_mis, q_base, q_pos} = ent_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !q_pop)
            cnt_next = cnt_reg + 2'd1;
        else if (!push && q_pop)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_reg <= !wr_reg;
            if (q_pop)
                rd_reg <= !rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_reg] <= ent;
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> in_stall)
        else $error("push into full queue");
endmodule

// ===== hdl/bpmc_back.sv =====
`timescale 1ns / 1ps
module bpmc_back #(
    parameter int unsigned WINDOW_DEPTH = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  logic                            q_hit,
    input  logic                            q_add,
    input  logic                            q_mis,
    input  logic [1:0]                      q_base,
    input  logic [$clog2(WINDOW_DEPTH)-1:0] q_pos,
    output logic                            q_pop,
    output logic                            clearing,
    output logic                            out_valid,
    output bpmc_pkg::out_item_t             out_item,
    input  logic                            out_stall
);
    import bpmc_pkg::*;
    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int C  = CW;
    localparam int NW = C + 7;
    localparam logic [C-1:0] CMAX = {C{1'b1}};

    // one memory word holds coverage, mismatches and four base counts
    logic [6*C-1:0] mem [WINDOW_DEPTH];
    logic [6*C-1:0] rdat_reg;
    logic [6*C-1:0] wdat;
    logic           we;
    logic [AW-1:0]  waddr;

    back_state_t    st_reg, st_next;
    logic [AW-1:0]  clr_reg, clr_next;
    logic           hit_reg, add_reg, mis_reg;
    logic [1:0]     base_reg;
    logic [AW-1:0]  pos_reg;
    logic [C-1:0]   cov_reg, mcnt_reg;
    logic [C-1:0]   cov_n, mcnt_n;
    logic [C-1:0]   bc [4];
    logic [C-1:0]   bc_n [4];
    logic [C-1:0]   best;
    logic [2:0]     dom;
    logic [2:0]     dom_reg;
    logic           weak_reg;
    logic [NW-1:0]  num_reg;
    logic [C:0]     rem_reg;
    logic [6:0]     quo_reg;
    logic [2:0]     bit_reg;
    logic [C:0]     rem_sh;
    logic           vld_reg;
    out_item_t      res_reg;

    function automatic logic [C-1:0] sat(input logic [C-1:0] v);
        return (v == CMAX) ? v : v + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdat;
        rdat_reg <= mem[pos_reg];
    end

    always_comb
    begin
        cov_n = rdat_reg[6*C-1 -: C];
        mcnt_n = rdat_reg[5*C-1 -: C];
        for (int i = 0; i < 4; i++)
        begin
            bc[i]   = rdat_reg[(i+1)*C-1 -: C];
            bc_n[i] = bc[i];
        end
        if (add_reg)
        begin
            cov_n = sat(cov_n);
            if (mis_reg)
            begin
                mcnt_n = sat(mcnt_n);
                bc_n[base_reg] = sat(bc[base_reg]);
            end
        end
        // tie order A, T, C, G
        best = bc_n[0];
        dom  = BASE_A;
        if (bc_n[3] > best) begin best = bc_n[3]; dom = BASE_T; end
        if (bc_n[1] > best) begin best = bc_n[1]; dom = BASE_C; end
        if (bc_n[2] > best) begin best = bc_n[2]; dom = BASE_G; end
        if (mcnt_n == '0)
            dom = BASE_N;
    end

    // shift the next numerator bit into the partial remainder
    assign rem_sh = {rem_reg[C-1:0], num_reg[6]};

    always_comb
    begin
        st_next  = st_reg;
        clr_next = clr_reg;
        q_pop    = 1'b0;
        we       = 1'b0;
        waddr    = pos_reg;
        wdat     = {cov_n, mcnt_n, bc_n[3], bc_n[2], bc_n[1], bc_n[0]};
        unique case (st_reg)
            ST_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg;
                wdat  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(WINDOW_DEPTH - 1))
                    st_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop   = 1'b1;
                    st_next = q_hit ? ST_READ : ST_OUT;
                end
            end
            ST_READ:  st_next = ST_WRITE;
            ST_WRITE:
            begin
                we      = add_reg;
                st_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (bit_reg == 3'd6)
                    st_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!vld_reg || !out_stall)
                    st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_CLEAR;
            clr_reg <= '0;
            vld_reg <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            clr_reg <= clr_next;
            if (st_reg == ST_OUT && (!vld_reg || !out_stall))
                vld_reg <= 1'b1;
            else if (!out_stall)
                vld_reg <= 1'b0;
        end
    end

    // restoring divider: (mis*100) / cov, seven quotient bits
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            hit_reg  <= q_hit;
            add_reg  <= q_add && q_hit;
            mis_reg  <= q_mis;
            base_reg <= q_base;
            pos_reg  <= q_pos;
        end
        if (st_reg == ST_WRITE)
        begin
            cov_reg  <= cov_n;
            mcnt_reg <= mcnt_n;
            dom_reg  <= dom;
            weak_reg <= (mcnt_n != '0) &&
                        (({4'b0, best} * (C+4)'(10)) < ({4'b0, mcnt_n} * (C+4)'(8)));
            // mis <= cov so quotient fits in 7 bits; pre-shift out top bits
            num_reg  <= NW'(mcnt_n * NW'(100));
            rem_reg  <= (C+1)'(NW'(mcnt_n * NW'(100)) >> 7);
            quo_reg  <= '0;
            bit_reg  <= '0;
        end
        else if (st_reg == ST_DIV)
        begin
            bit_reg <= bit_reg + 3'd1;
            num_reg <= {num_reg[NW-2:0], 1'b0};
            if (rem_sh >= {1'b0, cov_reg})
            begin
                rem_reg <= rem_sh - {1'b0, cov_reg};
                quo_reg <= {quo_reg[5:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[5:0], 1'b0};
            end
        end
        if (st_reg == ST_OUT && (!vld_reg || !out_stall))
        begin
            res_reg.in_window <= hit_reg;
            res_reg.coverage  <= hit_reg ? cov_reg : '0;
            res_reg.mismatch_total <= hit_reg ? mcnt_reg : '0;
            res_reg.mismatch_percent <= (hit_reg && cov_reg != '0) ? quo_reg : '0;
            res_reg.dominant_base <= hit_reg ? dom_reg : BASE_N;
            res_reg.dominant_weak <= hit_reg && weak_reg;
        end
    end

    assign clearing  = (st_reg == ST_CLEAR);
    assign out_valid = vld_reg;
    assign out_item  = res_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (st_reg == ST_IDLE))
        else $error("pop outside idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.in_window) |-> (out_item.mismatch_total <= out_item.coverage))
        else $error("mismatches exceed coverage");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.mismatch_percent <= 7'd100))
        else $error("percent out of range");
endmodule

// ===== hdl/base_pileup_mismatch_counter.sv =====
`timescale 1ns / 1ps
// Per-position base pileup with a mismatch histogram over a genome window.
// Input channel (in_valid/in_stall/in_item): one transaction adds one
// aligned base (mode add) or asks for one position's statistics (mode
// report). Output channel (out_valid/out_stall/out_item): exactly one
// transaction per input, in order, with the position's counts after it.
// Configuration: cfg_we writes cfg_index 0 (window start) or 1 (window
// length) with cfg_data; write only while the block is idle.
// Front end range-checks and classifies the item and pushes it into a
// two-entry queue. Back end does the read-modify-write of one memory word
// (coverage, mismatches, four base counts) and a 7-step restoring divide
// for the percentage. From the queue head, an in-window item passes the
// read, write, divide and output states, an out-of-window item goes to output
// only; one back-end sequencer and divider serve all items, one at a time.
// Reset: registers go to defaults and a clearing pass writes zero to every
// memory word; in_stall stays high during it.
// Receiver stall holds the result register; the back end waits and the
// queue fills, then in_stall rises.
module base_pileup_mismatch_counter #(
    parameter int unsigned WINDOW_DEPTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 in_valid,
    input  bpmc_pkg::in_item_t   in_item,
    output logic                 in_stall,
    output logic                 out_valid,
    output bpmc_pkg::out_item_t  out_item,
    input  logic                 out_stall
);
    import bpmc_pkg::*;
    localparam int AW = $clog2(WINDOW_DEPTH);

    logic [31:0]   start_reg;
    logic [10:0]   len_reg;
    logic          qv, qh, qa, qm, pop, clr;
    logic [1:0]    qb;
    logic [AW-1:0] qp;

    // hold window registers; to be written only when idle, which the block does not enforce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            len_reg   <= 11'd1001;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_WINDOW_START)
                start_reg <= cfg_data;
            else
                len_reg <= cfg_data[10:0];
        end
    end

    bpmc_front #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_front (
        .clk(clk), .rst_n(rst_n), .win_start(start_reg), .win_len(len_reg),
        .in_valid(in_valid), .in_item(in_item), .in_stall(in_stall),
        .q_valid(qv), .q_hit(qh), .q_add(qa), .q_mis(qm), .q_base(qb),
        .q_pos(qp), .q_pop(pop), .busy(clr)
    );

    bpmc_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(qv), .q_hit(qh), .q_add(qa),
        .q_mis(qm), .q_base(qb), .q_pos(qp), .q_pop(pop), .clearing(clr),
        .out_valid(out_valid), .out_item(out_item), .out_stall(out_stall)
    );
endmodule

// ===== tb/base_pileup_mismatch_counter_tb.sv =====
`timescale 1ns / 1ps
module base_pileup_mismatch_counter_tb;
    import bpmc_pkg::*;

    localparam int unsigned DEPTH     = 1024;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    // Clock, reset and every block input start at a known value.
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = REG_WINDOW_START;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    in_item_t    in_item = '0;
    logic        in_stall;
    logic        out_valid;
    out_item_t   out_item;
    logic        out_stall = 1'b0;

    base_pileup_mismatch_counter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_item  (out_item),
        .out_stall (out_stall)
    );

    always #5 clk = ~clk;

    // Shadow copy of the window registers and the pileup store.
    logic [31:0]   shadow_start = 32'd0;
    logic [10:0]   shadow_length = 11'd1001;
    logic [CW-1:0] cov_mem [DEPTH];
    logic [CW-1:0] mis_mem [DEPTH];
    logic [CW-1:0] base_mem [4*DEPTH];

    out_item_t expected_stats_q[$];
    int        error_count = 0;
    int        sent_count = 0;
    int        checked_count = 0;
    int        config_count = 0;

    // Idle rates in percent and a requested long receiver hold-off.
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int hold_request = 0;
    int hold_left = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        error_count++;
    endtask

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // Apply one transaction to the shadow store and return its statistics.
    function automatic out_item_t pileup_predict(input in_item_t it);
        out_item_t   r;
        logic [2:0]  rb;
        logic [2:0]  fb;
        logic [31:0] eff_len;
        logic [31:0] pos;
        logic [2:0]  dom;
        logic [CW-1:0] best;
        logic [CW-1:0] cnt;
        logic [63:0] pct;
        logic [2:0]  tie_order [4];
        r = '0;
        r.dominant_base = BASE_N;
        tie_order[0] = BASE_A;
        tie_order[1] = BASE_T;
        tie_order[2] = BASE_C;
        tie_order[3] = BASE_G;
        rb = (it.read_base > BASE_N) ? BASE_N : it.read_base;
        fb = (it.ref_base > BASE_N) ? BASE_N : it.ref_base;
        eff_len = (shadow_length > DEPTH) ? DEPTH : 32'(shadow_length);
        if (it.location < shadow_start || (it.location - shadow_start) >= eff_len)
            return r;
        pos = (it.location - shadow_start) % DEPTH;
        if (it.mode == MODE_ADD)
        begin
            cov_mem[pos] = sat_inc(cov_mem[pos]);
            if (rb != BASE_N && fb != BASE_N && rb != fb)
            begin
                mis_mem[pos] = sat_inc(mis_mem[pos]);
                base_mem[pos*4 + rb] = sat_inc(base_mem[pos*4 + rb]);
            end
        end
        r.in_window = 1'b1;
        r.coverage = cov_mem[pos];
        r.mismatch_total = mis_mem[pos];
        if (cov_mem[pos] != 0)
        begin
            pct = (64'(mis_mem[pos]) * 100) / 64'(cov_mem[pos]);
            r.mismatch_percent = (pct > 100) ? 7'd100 : pct[6:0];
        end
        if (mis_mem[pos] != 0)
        begin
            dom = tie_order[0];
            best = base_mem[pos*4 + tie_order[0]];
            for (int k = 1; k < 4; k++)
            begin
                cnt = base_mem[pos*4 + tie_order[k]];
                if (cnt > best)
                begin
                    best = cnt;
                    dom = tie_order[k];
                end
            end
            r.dominant_base = dom;
            r.dominant_weak = (64'(best) * 10 < 64'(mis_mem[pos]) * 8);
        end
        return r;
    endfunction

    // Offer one transaction, hold it until accepted, then record its prediction.
    task automatic send_item(input in_item_t it);
        int gap;
        gap = 0;
        if ($urandom_range(99) < sender_idle_pct)
            gap = $urandom_range(6, 1);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (in_stall);
        expected_stats_q.push_back(pileup_predict(it));
        sent_count++;
    endtask

    function automatic in_item_t make_item(input logic [0:0] m, input logic [31:0] loc,
                                           input logic [2:0] rb, input logic [2:0] fb);
        in_item_t it;
        it.mode = m;
        it.location = loc;
        it.read_base = rb;
        it.ref_base = fb;
        return it;
    endfunction

    // Drop valid and wait until every outstanding result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_stats_q.size() != 0)
            @(posedge clk);
        repeat (15) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_WINDOW_START)
            shadow_start = value;
        else
            shadow_length = value[10:0];
        config_count++;
    endtask

    // Mostly well-formed observations, many of them on a few hot positions, with
    // reports, out-of-window coordinates and raw noise mixed in.
    function automatic in_item_t random_item();
        in_item_t    it;
        logic [31:0] eff_len;
        int          r;
        eff_len = (shadow_length > DEPTH) ? DEPTH : 32'(shadow_length);
        r = $urandom_range(99);
        it.mode = ($urandom_range(99) < 15) ? MODE_REPORT : MODE_ADD;
        it.read_base = ($urandom_range(9) == 0) ? 3'($urandom_range(7))
                                                 : 3'($urandom_range(3));
        it.ref_base = ($urandom_range(9) == 0) ? 3'($urandom_range(7))
                                                : 3'($urandom_range(3));
        if (r < 8 || eff_len == 0)
            it = in_item_t'({$urandom, $urandom});
        else if (r < 15)
            it.location = ($urandom_range(1) != 0)
                ? shadow_start - 32'($urandom_range(4, 1))
                : shadow_start + eff_len + 32'($urandom_range(3));
        else if (r < 60)
            it.location = shadow_start + 32'($urandom_range(7) % eff_len);
        else
            it.location = shadow_start + 32'($urandom_range(eff_len - 1));
        return it;
    endfunction

    task automatic send_random(input int count);
        repeat (count) send_item(random_item());
    endtask

    // Drive stall from random idling, or hold it high for a requested stretch.
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_stats_q.size() == 0)
                report_mismatch("result with no transaction outstanding");
            else
            begin
                exp_r = expected_stats_q.pop_front();
                checked_count++;
                if (out_item.in_window !== exp_r.in_window)
                    report_mismatch($sformatf("in_window %0b, want %0b",
                                              out_item.in_window, exp_r.in_window));
                if (out_item.coverage !== exp_r.coverage)
                    report_mismatch($sformatf("coverage %0d, want %0d",
                                              out_item.coverage, exp_r.coverage));
                if (out_item.mismatch_total !== exp_r.mismatch_total)
                    report_mismatch($sformatf("mismatch_total %0d, want %0d",
                                              out_item.mismatch_total, exp_r.mismatch_total));
                if (out_item.mismatch_percent !== exp_r.mismatch_percent)
                    report_mismatch($sformatf("mismatch_percent %0d, want %0d",
                                              out_item.mismatch_percent,
                                              exp_r.mismatch_percent));
                if (out_item.dominant_base !== exp_r.dominant_base)
                    report_mismatch($sformatf("dominant_base %0d, want %0d",
                                              out_item.dominant_base, exp_r.dominant_base));
                if (out_item.dominant_weak !== exp_r.dominant_weak)
                    report_mismatch($sformatf("dominant_weak %0b, want %0b",
                                              out_item.dominant_weak, exp_r.dominant_weak));
            end
        end
    end

    // Directed: matches, mismatches, N bases, illegal codes, ties, window edges.
    task automatic test_directed();
        send_item(make_item(MODE_REPORT, 32'd5, BASE_A, BASE_A));     // zero coverage
        send_item(make_item(MODE_ADD, 32'd0, BASE_A, BASE_A));        // match
        send_item(make_item(MODE_ADD, 32'd0, BASE_C, BASE_A));
        send_item(make_item(MODE_ADD, 32'd0, BASE_T, BASE_A));
        send_item(make_item(MODE_ADD, 32'd0, BASE_N, BASE_G));        // N read
        send_item(make_item(MODE_ADD, 32'd0, BASE_G, BASE_N));        // N reference
        send_item(make_item(MODE_ADD, 32'd0, 3'd7, BASE_A));          // code 7 acts as N
        send_item(make_item(MODE_ADD, 32'd0, BASE_A, 3'd5));
        send_item(make_item(MODE_REPORT, 32'd0, BASE_C, BASE_A));     // report leaves state
        // Tie between C and G, then three-way tie with T.
        send_item(make_item(MODE_ADD, 32'd2, BASE_G, BASE_A));
        send_item(make_item(MODE_ADD, 32'd2, BASE_C, BASE_A));
        send_item(make_item(MODE_ADD, 32'd2, BASE_T, BASE_A));
        send_item(make_item(MODE_ADD, 32'd2, BASE_A, BASE_C));        // A wins all ties
        send_item(make_item(MODE_ADD, 32'd3, BASE_G, BASE_T));
        send_item(make_item(MODE_ADD, 32'd3, BASE_G, BASE_T));        // strong dominant
        send_item(make_item(MODE_ADD, 32'd1000, BASE_T, BASE_G));     // last position
        send_item(make_item(MODE_ADD, 32'd1001, BASE_T, BASE_G));     // just outside
        send_item(make_item(MODE_REPORT, 32'd1001, BASE_A, BASE_A));
        send_item(make_item(MODE_ADD, 32'hFFFF_FFFF, 3'd7, 3'd7));
        send_item(make_item(MODE_REPORT, 32'd1000, BASE_A, BASE_A));
    endtask

    // Window placed against the top coordinate, lengths clipped and empty.
    task automatic test_window_edges();
        write_reg(REG_WINDOW_START, 32'hFFFF_FF00);
        write_reg(REG_WINDOW_LENGTH, 32'd2047);                       // clipped to depth
        send_item(make_item(MODE_ADD, 32'hFFFF_FFFF, BASE_C, BASE_G));
        send_item(make_item(MODE_ADD, 32'hFFFF_FEFF, BASE_C, BASE_G));
        send_item(make_item(MODE_ADD, 32'd0, BASE_C, BASE_G));        // no wrap
        send_random(60);
        write_reg(REG_WINDOW_LENGTH, 32'd0);                          // nothing inside
        send_item(make_item(MODE_ADD, 32'hFFFF_FF00, BASE_A, BASE_C));
        send_random(20);
        write_reg(REG_WINDOW_START, 32'hFFFF_FFFF);
        write_reg(REG_WINDOW_LENGTH, 32'd1);
        send_item(make_item(MODE_ADD, 32'hFFFF_FFFF, BASE_T, BASE_A));
        send_item(make_item(MODE_REPORT, 32'hFFFF_FFFE, BASE_T, BASE_A));
        send_random(20);
    endtask

    // Random traffic over a few window settings in one idling phase.
    task automatic test_random_phase(input int s_pct, input int r_pct, input int count);
        sender_idle_pct = s_pct;
        receiver_idle_pct = r_pct;
        write_reg(REG_WINDOW_START, 32'd28608000);
        write_reg(REG_WINDOW_LENGTH, 32'd1001);
        send_random(count / 2);
        write_reg(REG_WINDOW_START, $urandom);
        write_reg(REG_WINDOW_LENGTH, 32'($urandom_range(24, 1)));
        send_random(count / 4);
        write_reg(REG_WINDOW_START, 32'd0);
        write_reg(REG_WINDOW_LENGTH, 32'd1024);
        send_random(count / 4);
    endtask

    // Hold the receiver off so the block backs up into its input, then drain.
    task automatic test_backpressure();
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        drain_results();
        hold_request = 300;
        send_random(40);
        drain_results();
        send_random(30);
    endtask

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cov_mem[i] = '0;
            mis_mem[i] = '0;
        end
        for (int i = 0; i < 4*DEPTH; i++)
            base_mem[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        sender_idle_pct = 31;
        receiver_idle_pct = 56;
        test_window_edges();
        test_random_phase(31, 56, 560);
        test_backpressure();
        test_random_phase(56, 31, 560);
        test_random_phase(0, 0, 400);
        drain_results();
        repeat (20) @(posedge clk);
        if (expected_stats_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_stats_q.size()));
        $display("Covered %0d transactions, %0d results checked, %0d register writes,",
                 sent_count, checked_count, config_count);
        $display("window edges, clipped and empty windows, ties and a long output hold-off.");
        if (error_count == 0)
            $display("base_pileup_mismatch_counter_tb passed");
        else
            $display("base_pileup_mismatch_counter_tb failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("base_pileup_mismatch_counter_tb failed");
        $finish;
    end

endmodule
